/* rtl/b64_pkg.sv */
// shared types, constants and the base64 alphabet function
// for the base64 stream encoder; no dependencies
package b64_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [1:0] FULL_GROUP = 2'd3;

	// one group of up to three bytes, ready to be turned into four characters
	typedef struct packed {
		logic [23:0] group;
		logic [1:0]  last_real;   // highest character index that is not padding
		logic        eot;
	} grp_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage

/* rtl/b64_in_if.sv */
// byte channel: valid/ready handshake with one raw byte and a last flag
// no dependencies
interface b64_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/b64_out_if.sv */
// character channel: valid/ready handshake with one ascii character
// no dependencies
interface b64_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       end_of_text;

	modport source (output valid, output out_char, output end_of_text, input ready);
	modport sink (input valid, input out_char, input end_of_text, output ready);
endinterface

/* rtl/b64_front.sv */
// front end: takes bytes, holds up to two, forms complete or padded groups
// depends on b64_pkg and b64_in_if
module b64_front
	import b64_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	b64_in_if.sink   byte_ch,
	input  logic     q_full,
	output logic     push,
	output grp_t     push_grp
);

	logic [15:0] pend_q;
	logic [1:0]  cnt_q;
	logic        xfer;

	assign byte_ch.ready = !q_full;
	assign xfer = byte_ch.valid && byte_ch.ready;

	always_comb begin
		push_grp.eot = byte_ch.last_byte;
		case (cnt_q)
			2'd2: begin
				push_grp.group     = {pend_q, byte_ch.data_byte};
				push_grp.last_real = FULL_GROUP;
			end
			2'd1: begin
				push_grp.group     = {pend_q[7:0], byte_ch.data_byte, 8'h00};
				push_grp.last_real = 2'd2;
			end
			default: begin
				push_grp.group     = {byte_ch.data_byte, 16'h0000};
				push_grp.last_real = 2'd1;
			end
		endcase
	end

	assign push = xfer && ((cnt_q == 2'd2) || byte_ch.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			pend_q <= 16'h0000;
		end else if (xfer) begin
			if (push) begin
				cnt_q  <= 2'd0;
				pend_q <= 16'h0000;
			end else if (cnt_q == 2'd1) begin
				cnt_q  <= 2'd2;
				pend_q <= {pend_q[7:0], byte_ch.data_byte};
			end else begin
				cnt_q  <= 2'd1;
				pend_q <= {8'h00, byte_ch.data_byte};
			end
		end
	end

endmodule

/* rtl/b64_fifo.sv */
// short group queue between the front and back ends
// depends on b64_pkg
module b64_fifo
	import b64_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  grp_t push_grp,
	input  logic pop,
	output grp_t pop_grp,
	output logic full,
	output logic empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	grp_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_grp = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/b64_back.sv */
// back end: walks a group one character per cycle, while the character port is ready, into the output register
// depends on b64_pkg and b64_out_if
module b64_back
	import b64_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  grp_t      q_grp,
	output logic      pop,
	b64_out_if.source char_ch
);

	grp_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       ovalid_q;
	logic [7:0] ochar_q;
	logic       oeot_q;
	logic       load;
	logic       done;
	logic [5:0] sextet;
	logic [7:0] next_char;

	assign load = cur_valid_q && (!ovalid_q || char_ch.ready);
	assign done = load && (idx_q == 2'd3);
	assign pop  = !q_empty && (!cur_valid_q || done);

	always_comb begin
		case (idx_q)
			2'd0:    sextet = cur_q.group[23:18];
			2'd1:    sextet = cur_q.group[17:12];
			2'd2:    sextet = cur_q.group[11:6];
			default: sextet = cur_q.group[5:0];
		endcase
		next_char = (idx_q > cur_q.last_real) ? PAD_CHAR : b64_char(sextet);
	end

	assign char_ch.valid       = ovalid_q;
	assign char_ch.out_char    = ochar_q;
	assign char_ch.end_of_text = oeot_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_grp;
		end
		if (load) begin
			ochar_q <= next_char;
			oeot_q  <= (idx_q == 2'd3) && cur_q.eot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			ovalid_q    <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else begin
				if (done) begin
					cur_valid_q <= 1'b0;
				end
				if (load) begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (char_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/base64_stream_encoder.sv */
// base64 stream encoder: one byte accepted per cycle while the group queue has room.
// a group goes out as four characters, one per cycle while the character port is ready, from a registered output.
// a closed group passes through the queue and the back end's group register before its first character is registered.
// sustained rate is set by the character port, which carries four characters for every three bytes.
// arst_n clears held bytes, the queue and the output valid flag; no characters pending.
module base64_stream_encoder
	import b64_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	b64_in_if.sink    byte_ch,
	b64_out_if.source char_ch
);

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	grp_t push_grp;
	grp_t pop_grp;

	b64_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.q_full   (q_full),
		.push     (push),
		.push_grp (push_grp)
	);

	b64_fifo #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.pop_grp  (pop_grp),
		.full     (q_full),
		.empty    (q_empty)
	);

	b64_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_grp   (pop_grp),
		.pop     (pop),
		.char_ch (char_ch)
	);

endmodule

/* rtl/b64_checker.sv */
// port-level checks on the encoder's character stream, bound to the top level
// depends on b64_pkg
module b64_checker
	import b64_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_eot
);

	logic [1:0] pos_q;
	logic       pad_q;
	logic       xfer;

	assign xfer = out_valid && out_ready;

	// position within the current four-character group and padding seen at position 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			pad_q <= 1'b0;
		end else if (xfer) begin
			pos_q <= pos_q + 2'd1;
			pad_q <= (pos_q == 2'd2) && (out_char == PAD_CHAR);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_eot))
		else $error("character changed while stalled");

	a_eot_pos: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && out_eot |-> pos_q == 2'd3)
		else $error("end_of_text off the fourth character of a group");

	a_pad_pos: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && out_char == PAD_CHAR |-> pos_q == 2'd2 || pos_q == 2'd3)
		else $error("padding in the first half of a group");

	a_pad_end: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && pos_q == 2'd3 && pad_q |-> out_char == PAD_CHAR && out_eot)
		else $error("double padding not closed by a final padded character");

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (char_ch.valid),
	.out_ready (char_ch.ready),
	.out_char  (char_ch.out_char),
	.out_eot   (char_ch.end_of_text)
);

/* tb/base64_stream_encoder_test.sv */
// self-checking testbench for base64_stream_encoder: directed messages, then random messages under four idling phases
// depends on rtl/b64_pkg.sv, rtl/b64_in_if.sv, rtl/b64_out_if.sv and the encoder rtl
`timescale 1ns / 100ps

module base64_stream_encoder_test;
	import b64_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 65;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct {
		logic [7:0] code;
		logic       eot;
	} b64_char_t;

	class b64_scoreboard;
		logic [15:0] held_bytes;
		logic [1:0]  held_count;
		b64_char_t   expected_chars[$];
		int          errors;

		function new();
			held_bytes = '0;
			held_count = '0;
			errors = 0;
		endfunction

		function logic [7:0] sextet_code(logic [23:0] grp, int pos);
			logic [5:0] idx;
			idx = grp[18 - 6 * pos +: 6];
			return ALPHABET[8 * (63 - idx) +: 8];
		endfunction

		// queue four characters; positions past last_real become padding
		function void push_group(logic [23:0] grp, int last_real, logic eot);
			b64_char_t c;
			for (int k = 0; k < 4; k++) begin
				c.code = (k <= last_real) ? sextet_code(grp, k) : PAD_CHAR;
				c.eot = (k == 3) ? eot : 1'b0;
				expected_chars.push_back(c);
			end
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			if (held_count == 2'd2) begin
				push_group({held_bytes, b}, 3, last);
				held_bytes = '0;
				held_count = '0;
			end else begin
				if (held_count == 2'd0) begin
					held_bytes = {8'h00, b};
					held_count = 2'd1;
				end else begin
					held_bytes = {held_bytes[7:0], b};
					held_count = 2'd2;
				end
				if (last) begin
					if (held_count == 2'd1)
						push_group({held_bytes[7:0], 16'h0000}, 1, 1'b1);
					else
						push_group({held_bytes, 8'h00}, 2, 1'b1);
					held_bytes = '0;
					held_count = '0;
				end
			end
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_char(logic [7:0] code, logic eot);
			b64_char_t want;
			if (expected_chars.size() == 0) begin
				report($sformatf("unexpected char 0x%02h eot %0b", code, eot));
			end else begin
				want = expected_chars.pop_front();
				if (code !== want.code)
					report($sformatf("out_char 0x%02h, want 0x%02h", code, want.code));
				if (eot !== want.eot)
					report($sformatf("end_of_text %0b, want %0b", eot, want.eot));
			end
		endtask

		task finish_check();
			if (expected_chars.size() != 0)
				report($sformatf("%0d chars never arrived", expected_chars.size()));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   snk_stall_pct;
	int   idle_cycles;
	int   sent_items;
	b64_scoreboard sb;

	b64_in_if  byte_ch ();
	b64_out_if char_ch ();

	base64_stream_encoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch.sink),
		.char_ch (char_ch.source)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// one byte transfer; may idle the channel first
	task send_byte(logic [7:0] b, logic last);
		@(negedge clk);
		if ($urandom_range(99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last_byte <= last;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		sb.note_byte(b, last);
		sent_items++;
	endtask

	task send_message(logic [7:0] msg[$]);
		for (int i = 0; i < msg.size(); i++)
			send_byte(msg[i], i == msg.size() - 1);
	endtask

	task send_random_message(int len);
		logic [7:0] msg[$];
		for (int i = 0; i < len; i++)
			msg.push_back(8'($urandom_range(255)));
		send_message(msg);
	endtask

	initial begin
		char_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			char_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && char_ch.valid && char_ch.ready)
			sb.check_char(char_ch.out_char, char_ch.end_of_text);
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int phase_start;
		sb = new();
		idle_cycles = 0;
		sent_items = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.last_byte = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: single and double byte padding, zero and all-ones groups,
		// the two top alphabet entries, and groups completed inside longer messages
		send_message('{8'h00});
		send_message('{8'hFF});
		send_message('{8'hFF, 8'hFF});
		send_message('{8'h00, 8'h00, 8'h00});
		send_message('{8'hFB, 8'hEF, 8'hBE});
		send_message('{8'hFF, 8'hFF, 8'hFF});
		send_message('{8'h4D, 8'h61, 8'h6E, 8'h41});
		send_message('{8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55});

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1: begin src_idle_pct = 65; snk_stall_pct = 0; end
				2: begin src_idle_pct = 0; snk_stall_pct = 65; end
				default: begin src_idle_pct = 29; snk_stall_pct = 29; end
			endcase
			phase_start = sent_items;
			while (sent_items - phase_start < ITEMS_PER_PHASE) begin
				if ($urandom_range(9) < 8)
					send_random_message($urandom_range(1, 12));
				else
					send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
			end
		end

		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (sb.expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.finish_check();
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
